// ===== rtl/zlsc_pkg.sv =====
`default_nettype none

package zlsc_pkg;

  // Legacy key schedule constants
  localparam logic [31:0] KEY0_RESET = 32'h0808_973C;
  localparam logic [31:0] KEY1_RESET = 32'hDB59_23E5;
  localparam logic [31:0] KEY2_RESET = 32'h7A9E_8B29;
  localparam logic [31:0] KEY1_MULT  = 32'd134775813;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  // Key store: one entry holding all three key words
  localparam int unsigned KEY_RAM_DEPTH = 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0_START = 2'd0,
    REG_KEY1_START = 2'd1,
    REG_KEY2_START = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } key_set_t;

  localparam key_set_t KEYS_RESET = '{a: KEY0_RESET, b: KEY1_RESET, c: KEY2_RESET};

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
  } out_item_t;

  // Reflected CRC-32 lookup, built at elaboration
  function automatic logic [255:0][31:0] crc_lut_build();
    logic [255:0][31:0] tbl;
    logic [31:0]        r;
    for (int i = 0; i < 256; i++) begin
      r = 32'(i);
      for (int j = 0; j < 8; j++) begin
        r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      tbl[i] = r;
    end
    return tbl;
  endfunction

  localparam logic [255:0][31:0] CRC_LUT = crc_lut_build();

  // One CRC-32 byte step
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [7:0] idx;
    idx = crc[7:0] ^ b;
    return {8'h00, crc[31:8]} ^ CRC_LUT[idx];
  endfunction

  // Keystream byte from the third key word
  function automatic logic [7:0] keystream(input logic [31:0] kc);
    logic [15:0] t;
    logic [31:0] prod;
    t    = {kc[15:2], 2'b11};
    prod = {16'h0000, t} * {16'h0000, t ^ 16'h0001};
    return prod[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/zlsc_stream_if.sv =====
`default_nettype none

interface zlsc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/zip_legacy_stream_cipher.sv =====
// A byte taken in is captured with a key store read; its cipher byte is then registered
// to out_o once the output is free. Per byte: key store read, key0/key1 step with the
// 32-bit multiply, then key2 CRC step and key store write-back; no new byte before it.
// Reset: start registers and key words return to the legacy default keys at once;
// the key store is not swept, a valid flag selects the default keys until first write.
`default_nettype none

module zip_legacy_stream_cipher
  import zlsc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  zlsc_stream_if.sink                in_i,
  zlsc_stream_if.source              out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned RAM_AW = (KEY_RAM_DEPTH > 1) ? $clog2(KEY_RAM_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] key0_start_q, key1_start_q, key2_start_q;
  logic        key_valid_q;
  logic [7:0]  plain_q;
  logic        restart_q;
  logic        out_valid_q;
  logic [7:0]  cipher_q;

  logic        in_xfer, out_xfer, calc_go;
  key_set_t    ram_rdata, keys_cur, keys_next;
  logic [$bits(key_set_t)-1:0] ram_rdata_raw;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;
  assign calc_go    = (state_q == ST_CALC) && (!out_valid_q || out_o.ready);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_start_q <= KEY0_RESET;
      key1_start_q <= KEY1_RESET;
      key2_start_q <= KEY2_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY0_START: key0_start_q <= cfg_wdata_i;
        REG_KEY1_START: key1_start_q <= cfg_wdata_i;
        REG_KEY2_START: key2_start_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_CALC;
      ST_CALC: if (calc_go) state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FIN) begin
        key_valid_q <= 1'b1;
      end
      if (calc_go) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      plain_q   <= in_i.data.plain_byte;
      restart_q <= in_i.data.restart;
    end
  end

  // Key store
  zlsc_ram #(
    .WIDTH ($bits(key_set_t)),
    .DEPTH (KEY_RAM_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_FIN),
    .waddr_i (RAM_AW'(0)),
    .wdata_i (keys_next),
    .re_i    (in_xfer),
    .raddr_i (RAM_AW'(0)),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = key_set_t'(ram_rdata_raw);

  // Key source: restart reloads, else stored keys, else defaults after reset
  always_comb begin
    if (restart_q) begin
      keys_cur = '{a: key0_start_q, b: key1_start_q, c: key2_start_q};
    end else if (key_valid_q) begin
      keys_cur = ram_rdata;
    end else begin
      keys_cur = KEYS_RESET;
    end
  end

  zlsc_key_step u_key_step (
    .clk_i   (clk_i),
    .load_i  (calc_go),
    .keys_i  (keys_cur),
    .plain_i (plain_q),
    .keys_o  (keys_next)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (calc_go) begin
      cipher_q <= plain_q ^ keystream(keys_cur.c);
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.data.cipher_byte = cipher_q;

endmodule

`default_nettype wire

// ===== rtl/zlsc_ram.sv =====
`default_nettype none

module zlsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/zlsc_key_step.sv =====
`default_nettype none

module zlsc_key_step
  import zlsc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       load_i,
  input  wire key_set_t   keys_i,
  input  wire logic [7:0] plain_i,
  output key_set_t        keys_o
);

  logic [31:0] a_d, b_sum, b_d;
  logic [31:0] a_q, b_q, c_q;

  // First half: key0 CRC step, key1 add and multiply
  always_comb begin
    a_d   = crc_step(keys_i.a, plain_i);
    b_sum = keys_i.b + {24'h000000, a_d[7:0]};
    b_d   = b_sum * KEY1_MULT + 32'd1;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= keys_i.c;
    end
  end

  // Second half: key2 CRC step with the top byte of the new key1
  assign keys_o = '{a: a_q, b: b_q, c: crc_step(c_q, b_q[31:24])};

endmodule

`default_nettype wire
